/* rtl/core/lnaf_pkg.sv */
// ----------------------------------------------------------------------------
// lnaf_pkg
// Shared widths, register indexes, mode codes and gain limits of the leaky NLMS filter.
// ----------------------------------------------------------------------------
package lnaf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MODE_W     = 2;
  localparam int DELAY_W    = 9;
  localparam int TAP_W      = 8;
  localparam int STEP_W     = 16;
  localparam int WEIGHT_W   = 24;
  localparam int NUM_W      = 60;
  localparam int GMAG_W     = 41;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAK  = 3'd4;

  localparam logic [MODE_W-1:0] MODE_NOISE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NOTCH  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BYPASS = 2'd2;
  // undefined code, behaves as bypass
  localparam logic [MODE_W-1:0] MODE_RSVD   = 2'd3;

  localparam logic [NUM_W-1:0]  GAIN_CLAMP = 60'h100_0000_0000;
  localparam logic [GMAG_W-1:0] GAIN_MAX   = 41'h100_0000_0000;

endpackage

/* rtl/core/lnaf_in_if.sv */
// ----------------------------------------------------------------------------
// lnaf_in_if
// Sample input channel: valid/ready with one complex sample per beat.
// ----------------------------------------------------------------------------
interface lnaf_in_if;
  import lnaf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_re;
  sample_t sample_im;

  modport source (output valid, output sample_re, output sample_im, input ready);
  modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface

/* rtl/core/lnaf_out_if.sv */
// ----------------------------------------------------------------------------
// lnaf_out_if
// Result channel: valid/ready with one complex output per beat.
// ----------------------------------------------------------------------------
interface lnaf_out_if;
  import lnaf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t out_re;
  sample_t out_im;

  modport source (output valid, output out_re, output out_im, input ready);
  modport sink   (input valid, input out_re, input out_im, output ready);
endinterface

/* rtl/core/lnaf_div.sv */
// ----------------------------------------------------------------------------
// lnaf_div
// Radix-2 restoring divider, one quotient bit per cycle, NUM_W quotient bits.
// ----------------------------------------------------------------------------
module lnaf_div #(
  parameter int NUM_W = 60,
  parameter int DEN_W = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W:0]   sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign sh   = {rem_r, num_r[NUM_W-1]};
  assign ge   = sh >= {1'b0, den_r};
  assign diff = sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        quo_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
        num_r <= {num_r[NUM_W-2:0], 1'b0};
        quo_r <= {quo_r[NUM_W-2:0], ge};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;
endmodule

/* rtl/core/leaky_nlms_adaptive_filter.sv */
// ----------------------------------------------------------------------------
// leaky_nlms_adaptive_filter
// Complex leaky normalized LMS line enhancer over a sample ring and a weight
// memory, both single-port-write synchronous RAMs.
// ----------------------------------------------------------------------------
// After reset the block sweeps both memories to zero over max(RING_DEPTH,
// MAX_TAPS) addresses (512 by default) and takes no sample meanwhile. An
// adapting sample then takes one pass of taps reads of the ring and weight
// RAMs for prediction and power, a 60-step restoring division for the
// normalized gain, and a second pass of taps read-modify-writes of the
// weight RAM. A bypass sample skips both passes and the division. One sample
// is in work at a time; the result register lets the next sample be accepted
// while the last result waits.
// ----------------------------------------------------------------------------
module leaky_nlms_adaptive_filter #(
  parameter int RING_DEPTH = 512,
  parameter int MAX_TAPS   = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lnaf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lnaf_pkg::CFG_DATA_W-1:0]  cfg_data,
  lnaf_in_if.sink                          in_chan,
  lnaf_out_if.source                       out_chan
);
  import lnaf_pkg::*;

  localparam int RW    = $clog2(RING_DEPTH);
  localparam int WW    = $clog2(MAX_TAPS);
  localparam int TW    = $clog2(MAX_TAPS + 1);
  localparam int CMPW  = (TW > TAP_W) ? TW : TAP_W;
  localparam int BW    = ((RW > DELAY_W) ? RW : DELAY_W) + 1;
  localparam int CLR_N = (RING_DEPTH > MAX_TAPS) ? RING_DEPTH : MAX_TAPS;
  localparam int CLW   = $clog2(CLR_N);
  localparam int AW    = 41 + WW;
  localparam int PW    = 33 + WW;
  localparam int PRW   = AW - 22;
  localparam int ERW   = PRW + 1;

  localparam logic signed [AW-1:0]  RND22 = AW'(2 ** 21);
  localparam logic signed [PRW-1:0] P_MAX = PRW'(32767);
  localparam logic signed [PRW-1:0] P_MIN = PRW'(-32768);
  localparam logic signed [ERW-1:0] E_MAX = ERW'(32767);
  localparam logic signed [ERW-1:0] E_MIN = ERW'(-32768);
  localparam logic signed [ERW-1:0] E_MAX24 = ERW'(8388607);
  localparam logic signed [ERW-1:0] E_MIN24 = ERW'(-8388608);
  localparam logic signed [57:0]    RND32 = 58'sd2147483648;
  localparam logic signed [58:0]    RND14 = 59'sd8192;
  localparam logic signed [45:0]    W_MAX = 46'sd8388607;
  localparam logic signed [45:0]    W_MIN = -46'sd8388608;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_BASE, S_P1, S_P1D, S_ERR, S_NUM, S_DIV, S_P2, S_P2D, S_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic [MODE_W-1:0]  mode_r;
  logic [DELAY_W-1:0] delay_r;
  logic [TAP_W-1:0]   tapcnt_r;
  logic [STEP_W-1:0]  mu_r;
  logic [STEP_W-1:0]  leak_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_NOISE;
      delay_r  <= '0;
      tapcnt_r <= TAP_W'(64);
      mu_r     <= STEP_W'(1024);
      leak_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:  mode_r   <= cfg_data[MODE_W-1:0];
        CFG_DELAY: delay_r  <= cfg_data[DELAY_W-1:0];
        CFG_TAPS:  tapcnt_r <= cfg_data[TAP_W-1:0];
        CFG_STEP:  mu_r     <= cfg_data[STEP_W-1:0];
        CFG_LEAK:  leak_r   <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // control and datapath registers
  logic [CLW-1:0]    clr_r;
  logic [RW-1:0]     ptr_r;
  logic [BW-1:0]     base_r;
  logic [RW-1:0]     k_r;
  logic [TW-1:0]     j_r;
  logic [TW-1:0]     taps_r;
  logic              p2_r;
  logic              v1_r, v2_r, v3_r;
  logic [WW-1:0]     idx1_r, idx2_r, idx3_r;
  sample_t           x_re_r, x_im_r;
  sample_t           res_re_r, res_im_r;
  logic signed [AW-1:0] acc_re_r, acc_im_r;
  logic [PW-1:0]     pow_r;
  logic [PW-1:0]     power_r;
  weight_t           e24_re_r, e24_im_r;
  logic              neg_re_r, neg_im_r;
  logic [39:0]       nume_re_r, nume_im_r;
  logic [32:0]       s1_r;
  logic              div_start_r;
  logic signed [GMAG_W:0] g_re_r, g_im_r;
  logic signed [39:0] m_rr_r, m_ii_r, m_ri_r, m_ir_r;
  logic [32:0]       sq_r;
  logic signed [57:0] q_wsr_r, q_wsi_r, q_rr_r, q_ii_r, q_ri_r, q_ir_r;
  logic [47:0]       wnew_r;
  logic              out_valid_r;
  sample_t           out_re_r, out_im_r;

  // memories
  logic [31:0] ring_mem [RING_DEPTH];
  logic [47:0] w_mem [MAX_TAPS];
  logic [31:0] ring_rd_r;
  logic [47:0] w_rd_r;
  logic        ring_we, w_we;
  logic [RW-1:0] ring_wa;
  logic [WW-1:0] w_wa;
  logic [31:0] ring_wd;
  logic [47:0] w_wd;

  logic accept, adapt, clearing, issue;
  logic [CMPW-1:0] tapc;
  logic [TW-1:0]   taps_lim;

  assign accept   = in_chan.valid && (state_r == S_IDLE);
  assign adapt    = (mode_r == MODE_NOISE) || (mode_r == MODE_NOTCH);
  assign clearing = (state_r == S_CLEAR);
  assign issue    = ((state_r == S_P1) || (state_r == S_P2)) && (j_r < taps_r);
  assign tapc     = CMPW'(tapcnt_r);
  assign taps_lim = (tapc > CMPW'(MAX_TAPS)) ? TW'(MAX_TAPS) : TW'(tapc);

  assign ring_we = (clearing && ({1'b0, clr_r} < (CLW + 1)'(RING_DEPTH))) ||
                   (accept && adapt);
  assign ring_wa = clearing ? clr_r[RW-1:0] : ptr_r;
  assign ring_wd = clearing ? '0 : {in_chan.sample_re, in_chan.sample_im};
  assign w_we    = (clearing && ({1'b0, clr_r} < (CLW + 1)'(MAX_TAPS))) || v3_r;
  assign w_wa    = clearing ? clr_r[WW-1:0] : idx3_r;
  assign w_wd    = clearing ? '0 : wnew_r;

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ring_wa] <= ring_wd;
    ring_rd_r <= ring_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (w_we) w_mem[w_wa] <= w_wd;
    w_rd_r <= w_mem[j_r[WW-1:0]];
  end

  // tap data out of the RAMs
  sample_t dr, di;
  weight_t wr, wi;
  logic signed [31:0] sqr, sqi;
  logic signed [33:0] s1s;

  assign dr  = ring_rd_r[31:16];
  assign di  = ring_rd_r[15:0];
  assign wr  = w_rd_r[47:24];
  assign wi  = w_rd_r[23:0];
  assign sqr = dr * dr;
  assign sqi = di * di;
  assign s1s = $signed({1'b0, s1_r});

  // prediction and error
  logic signed [AW-1:0]  t_re, t_im;
  logic signed [PRW-1:0] pr_re, pr_im;
  logic signed [ERW-1:0] er_re, er_im;
  sample_t pr16_re, pr16_im, er16_re, er16_im;
  weight_t es_re, es_im;

  always_comb begin
    t_re  = acc_re_r + RND22;
    t_im  = acc_im_r + RND22;
    pr_re = $signed(t_re[AW-1:22]);
    pr_im = $signed(t_im[AW-1:22]);
    er_re = ERW'(x_re_r) - ERW'(pr_re);
    er_im = ERW'(x_im_r) - ERW'(pr_im);
    pr16_re = (pr_re > P_MAX) ? 16'sh7FFF : (pr_re < P_MIN) ? 16'sh8000 : pr_re[15:0];
    pr16_im = (pr_im > P_MAX) ? 16'sh7FFF : (pr_im < P_MIN) ? 16'sh8000 : pr_im[15:0];
    er16_re = (er_re > E_MAX) ? 16'sh7FFF : (er_re < E_MIN) ? 16'sh8000 : er_re[15:0];
    er16_im = (er_im > E_MAX) ? 16'sh7FFF : (er_im < E_MIN) ? 16'sh8000 : er_im[15:0];
    es_re = (er_re > E_MAX24) ? 24'sh7FFFFF : (er_re < E_MIN24) ? 24'sh800000 : er_re[23:0];
    es_im = (er_im > E_MAX24) ? 24'sh7FFFFF : (er_im < E_MIN24) ? 24'sh800000 : er_im[23:0];
  end

  // normalized gain
  logic [WEIGHT_W-1:0] mag_re, mag_im;
  logic [NUM_W-1:0]    q_re, q_im;
  logic                done_re, done_im;
  logic [GMAG_W-1:0]   gm_re, gm_im;

  assign mag_re = e24_re_r[WEIGHT_W-1] ? WEIGHT_W'(-e24_re_r) : e24_re_r;
  assign mag_im = e24_im_r[WEIGHT_W-1] ? WEIGHT_W'(-e24_im_r) : e24_im_r;
  assign gm_re  = (q_re > GAIN_CLAMP) ? GAIN_MAX : q_re[GMAG_W-1:0];
  assign gm_im  = (q_im > GAIN_CLAMP) ? GAIN_MAX : q_im[GMAG_W-1:0];

  lnaf_div #(.NUM_W(NUM_W), .DEN_W(PW)) u_div_re (
    .clk(clk), .rst_n(rst_n), .start(div_start_r),
    .num({nume_re_r, 20'd0}), .den(power_r), .done(done_re), .quot(q_re)
  );

  lnaf_div #(.NUM_W(NUM_W), .DEN_W(PW)) u_div_im (
    .clk(clk), .rst_n(rst_n), .start(div_start_r),
    .num({nume_im_r, 20'd0}), .den(power_r), .done(done_im), .quot(q_im)
  );

  // weight update
  logic signed [57:0] tw_re, tw_im;
  logic signed [58:0] dd_re, dd_im;
  logic signed [45:0] n_re, n_im;
  weight_t            ns_re, ns_im;

  always_comb begin
    tw_re = q_wsr_r + RND32;
    tw_im = q_wsi_r + RND32;
    dd_re = 59'(q_rr_r) - 59'(q_ii_r) + RND14;
    dd_im = 59'(q_ri_r) + 59'(q_ir_r) + RND14;
    n_re  = 46'($signed(tw_re[57:32])) + 46'($signed(dd_re[58:14]));
    n_im  = 46'($signed(tw_im[57:32])) + 46'($signed(dd_im[58:14]));
    ns_re = (n_re > W_MAX) ? 24'sh7FFFFF : (n_re < W_MIN) ? 24'sh800000 : n_re[23:0];
    ns_im = (n_im > W_MAX) ? 24'sh7FFFFF : (n_im < W_MIN) ? 24'sh800000 : n_im[23:0];
  end

  // tap pipeline: RAM data, products, accumulate or write back
  always_ff @(posedge clk) begin
    idx1_r <= j_r[WW-1:0];
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    if (v1_r) begin
      m_rr_r  <= wr * dr;
      m_ii_r  <= wi * di;
      m_ri_r  <= wr * di;
      m_ir_r  <= wi * dr;
      sq_r    <= 33'(sqr) + 33'(sqi);
      q_wsr_r <= wr * s1s;
      q_wsi_r <= wi * s1s;
      q_rr_r  <= g_re_r * dr;
      q_ii_r  <= g_im_r * di;
      q_ri_r  <= g_re_r * di;
      q_ir_r  <= g_im_r * dr;
    end
    if (v2_r && p2_r) wnew_r <= {ns_re, ns_im};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      ptr_r       <= '0;
      j_r         <= '0;
      taps_r      <= '0;
      p2_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= issue;
      v2_r        <= v1_r;
      v3_r        <= v2_r && p2_r;
      div_start_r <= 1'b0;
      if (out_valid_r && out_chan.ready && (state_r != S_FIN)) out_valid_r <= 1'b0;

      if (v2_r && !p2_r) begin
        acc_re_r <= acc_re_r + AW'(m_rr_r) + AW'(m_ii_r);
        acc_im_r <= acc_im_r + AW'(m_ri_r) - AW'(m_ir_r);
        pow_r    <= pow_r + PW'(sq_r);
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + CLW'(1);
          if (clr_r == CLW'(CLR_N - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            x_re_r <= in_chan.sample_re;
            x_im_r <= in_chan.sample_im;
            if (adapt) begin
              acc_re_r <= '0;
              acc_im_r <= '0;
              pow_r    <= '0;
              base_r   <= BW'(ptr_r) + BW'(delay_r);
              taps_r   <= taps_lim;
              state_r  <= S_BASE;
            end else begin
              res_re_r <= in_chan.sample_re;
              res_im_r <= in_chan.sample_im;
              state_r  <= S_FIN;
            end
          end
        end
        S_BASE: begin
          if (base_r >= BW'(RING_DEPTH)) begin
            base_r <= base_r - BW'(RING_DEPTH);
          end else begin
            k_r     <= base_r[RW-1:0];
            j_r     <= '0;
            p2_r    <= 1'b0;
            state_r <= S_P1;
          end
        end
        S_P1, S_P2: begin
          if (issue) begin
            j_r <= j_r + TW'(1);
            k_r <= (k_r == RW'(RING_DEPTH - 1)) ? '0 : k_r + RW'(1);
          end else begin
            state_r <= (state_r == S_P1) ? S_P1D : S_P2D;
          end
        end
        S_P1D: begin
          if (!v1_r && !v2_r) state_r <= S_ERR;
        end
        S_ERR: begin
          res_re_r <= (mode_r == MODE_NOISE) ? pr16_re : er16_re;
          res_im_r <= (mode_r == MODE_NOISE) ? pr16_im : er16_im;
          e24_re_r <= es_re;
          e24_im_r <= es_im;
          power_r  <= pow_r + PW'(1);
          state_r  <= S_NUM;
        end
        S_NUM: begin
          neg_re_r    <= e24_re_r[WEIGHT_W-1];
          neg_im_r    <= e24_im_r[WEIGHT_W-1];
          nume_re_r   <= mag_re * mu_r;
          nume_im_r   <= mag_im * mu_r;
          s1_r        <= 33'h1_0000_0000 - 33'(mu_r * leak_r);
          div_start_r <= 1'b1;
          state_r     <= S_DIV;
        end
        S_DIV: begin
          if (done_re) begin
            g_re_r  <= neg_re_r ? -$signed({1'b0, gm_re}) : $signed({1'b0, gm_re});
            g_im_r  <= neg_im_r ? $signed({1'b0, gm_im}) : -$signed({1'b0, gm_im});
            k_r     <= base_r[RW-1:0];
            j_r     <= '0;
            p2_r    <= 1'b1;
            state_r <= S_P2;
          end
        end
        S_P2D: begin
          if (!v1_r && !v2_r && !v3_r) begin
            ptr_r   <= (ptr_r == '0) ? RW'(RING_DEPTH - 1) : ptr_r - RW'(1);
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_chan.ready) begin
            out_re_r    <= res_re_r;
            out_im_r    <= res_im_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.out_re = out_re_r;
  assign out_chan.out_im = out_im_r;

  a_ptr_step: assert property (@(posedge clk) disable iff (!rst_n)
    (ptr_r != $past(ptr_r)) |->
      (ptr_r == (($past(ptr_r) == '0) ? RW'(RING_DEPTH - 1) : $past(ptr_r) - RW'(1))))
    else $error("ring pointer moved by other than one step back");

  a_div_lock: assert property (@(posedge clk) disable iff (!rst_n)
    done_re == done_im)
    else $error("dividers out of step");

  a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P1 || state_r == S_P2) |-> (j_r <= taps_r))
    else $error("tap index past tap count");

  a_wr_pass2: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (state_r == S_P2 || state_r == S_P2D))
    else $error("weight write outside update pass");
endmodule

/* tb/sv/lnaf_checker.sv */
// ----------------------------------------------------------------------------
// lnaf_checker
// Watches the sample, result and register ports of the leaky NLMS filter.
// It keeps its own copy of the ring, the weights and the registers, predicts
// each output beat in fixed point and compares it with the observed beat.
// ----------------------------------------------------------------------------
module lnaf_checker
  import lnaf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lnaf_in_if                    in_mon,
  lnaf_out_if                   out_mon,
  output int                    fail_count,
  output int                    backlog
);

  localparam int RING = 512;
  localparam int TAPS = 128;
  localparam longint W_HI = 64'sd8388607;
  localparam longint W_LO = -64'sd8388608;
  localparam longint unsigned G_LIM = 64'd1099511627776;

  typedef struct packed {
    sample_t re;
    sample_t im;
  } cplx_t;

  sample_t ring_re [RING];
  sample_t ring_im [RING];
  longint  w_re [TAPS];
  longint  w_im [TAPS];
  int      ring_ptr;

  logic [MODE_W-1:0]  mode_r;
  logic [DELAY_W-1:0] delay_r;
  logic [TAP_W-1:0]   taps_r;
  logic [STEP_W-1:0]  step_r;
  logic [STEP_W-1:0]  leak_r;

  cplx_t expected_out_q [$];

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint gain_of(longint e, longint unsigned pwr);
    longint unsigned mag;
    longint unsigned q;
    mag = (e < 0) ? longint'(-e) : longint'(e);
    q = ((mag * longint'(step_r)) << 20) / pwr;
    if (q > G_LIM) q = G_LIM;
    return (e < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic cplx_t enhance_sample(sample_t xr16, sample_t xi16);
    cplx_t res;
    longint xr, xi, dr, di, acc_r, acc_i, pr, pi, er, ei, gr, gi, yr, yi;
    longint nr, ni, s1;
    longint unsigned pwr;
    int n, k;
    xr = xr16;
    xi = xi16;
    if (mode_r != MODE_NOISE && mode_r != MODE_NOTCH) begin
      res.re = xr16;
      res.im = xi16;
      return res;
    end
    n = (taps_r > TAPS) ? TAPS : int'(taps_r);
    ring_re[ring_ptr] = xr16;
    ring_im[ring_ptr] = xi16;
    acc_r = 0;
    acc_i = 0;
    pwr = 0;
    for (int j = 0; j < n; j++) begin
      k = (ring_ptr + int'(delay_r) + j) % RING;
      dr = ring_re[k];
      di = ring_im[k];
      pwr += longint'(dr * dr + di * di);
      acc_r += w_re[j] * dr + w_im[j] * di;
      acc_i += w_re[j] * di - w_im[j] * dr;
    end
    pwr += 1;
    pr = rnd_shift(acc_r, 22);
    pi = rnd_shift(acc_i, 22);
    er = xr - pr;
    ei = xi - pi;
    gr = gain_of(clip(er, W_LO, W_HI), pwr);
    gi = -gain_of(clip(ei, W_LO, W_HI), pwr);
    s1 = (64'sd1 <<< 32) - longint'(step_r) * longint'(leak_r);
    for (int j = 0; j < n; j++) begin
      k = (ring_ptr + int'(delay_r) + j) % RING;
      dr = ring_re[k];
      di = ring_im[k];
      nr = rnd_shift(w_re[j] * s1, 32) + rnd_shift(gr * dr - gi * di, 14);
      ni = rnd_shift(w_im[j] * s1, 32) + rnd_shift(gr * di + gi * dr, 14);
      w_re[j] = clip(nr, W_LO, W_HI);
      w_im[j] = clip(ni, W_LO, W_HI);
    end
    ring_ptr = (ring_ptr + RING - 1) % RING;
    if (mode_r == MODE_NOISE) begin
      yr = pr;
      yi = pi;
    end else begin
      yr = er;
      yi = ei;
    end
    res.re = sample_t'(clip(yr, -32768, 32767));
    res.im = sample_t'(clip(yi, -32768, 32767));
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign backlog = expected_out_q.size();

  always @(posedge clk) begin
    cplx_t exp_b;
    if (!rst_n) begin
      for (int i = 0; i < RING; i++) begin
        ring_re[i] = '0;
        ring_im[i] = '0;
      end
      for (int i = 0; i < TAPS; i++) begin
        w_re[i] = 0;
        w_im[i] = 0;
      end
      ring_ptr = 0;
      mode_r = MODE_NOISE;
      delay_r = '0;
      taps_r = 8'd64;
      step_r = 16'd1024;
      leak_r = '0;
      expected_out_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE: begin
            mode_r = cfg_data[MODE_W-1:0];
          end
          CFG_DELAY: begin
            delay_r = cfg_data[DELAY_W-1:0];
          end
          CFG_TAPS: begin
            taps_r = cfg_data[TAP_W-1:0];
          end
          CFG_STEP: begin
            step_r = cfg_data;
          end
          CFG_LEAK: begin
            leak_r = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        expected_out_q.push_back(enhance_sample(in_mon.sample_re, in_mon.sample_im));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_out_q.size() == 0) begin
          report_mismatch("unexpected beat, re", out_mon.out_re, 0);
        end else begin
          exp_b = expected_out_q.pop_front();
          if (out_mon.out_re !== exp_b.re) report_mismatch("out_re", out_mon.out_re, exp_b.re);
          if (out_mon.out_im !== exp_b.im) report_mismatch("out_im", out_mon.out_im, exp_b.im);
        end
      end
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the leaky NLMS filter: directed extremes and
// special cases, then random register settings with tone-like and full-range
// samples, random gaps on both channels, a long result hold-off and pauses
// until drained. Checking is done by lnaf_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import lnaf_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lnaf_in_if  in_chan ();
  lnaf_out_if out_chan ();

  int  fail_count;
  int  backlog;
  int  n_in;
  int  n_out;
  int  items_sent;
  bit  no_idle;
  bit  hold_req;
  sample_t tone_re [8];
  sample_t tone_im [8];

  leaky_nlms_adaptive_filter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  lnaf_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .backlog    (backlog)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      n_in  <= 0;
      n_out <= 0;
    end else begin
      if (in_chan.valid && in_chan.ready) n_in <= n_in + 1;
      if (out_chan.valid && out_chan.ready) n_out <= n_out + 1;
    end
  end

  // result side: random stalls, long hold-off on request
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_chan.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_req = 1'b0;
      end
      out_chan.ready <= (no_idle || $urandom_range(99) >= 28);
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_beat(sample_t re, sample_t im);
    while (!no_idle && $urandom_range(99) < 28) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.sample_re <= re;
    in_chan.sample_im <= im;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (n_out != n_in) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_regs(int md, int dl, int tp, int st, int lk);
    cfg_write(CFG_MODE, CFG_DATA_W'(md));
    cfg_write(CFG_DELAY, CFG_DATA_W'(dl));
    cfg_write(CFG_TAPS, CFG_DATA_W'(tp));
    cfg_write(CFG_STEP, CFG_DATA_W'(st));
    cfg_write(CFG_LEAK, CFG_DATA_W'(lk));
  endtask

  // kind 0: full range, 1: repeating tone with noise, 2: extremes only
  task automatic run_phase(int count, int kind);
    sample_t re, im;
    int amp;
    amp = 1 << $urandom_range(15, 4);
    for (int i = 0; i < 8; i++) begin
      tone_re[i] = sample_t'($urandom);
      tone_im[i] = sample_t'($urandom);
    end
    for (int i = 0; i < count; i++) begin
      case (kind)
        0: begin
          re = sample_t'($urandom);
          im = sample_t'($urandom);
        end
        1: begin
          re = sample_t'((int'(tone_re[i % 8]) * amp) >>> 15) +
               sample_t'($urandom_range(15)) - sample_t'(8);
          im = sample_t'((int'(tone_im[i % 8]) * amp) >>> 15) +
               sample_t'($urandom_range(15)) - sample_t'(8);
        end
        default: begin
          re = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
          im = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        end
      endcase
      send_beat(re, im);
    end
    drain();
  endtask

  initial begin
    int md;
    int tp;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_chan.valid = 1'b0;
    in_chan.sample_re = '0;
    in_chan.sample_im = '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults, then register extremes and special cases
    send_beat(16'sh7fff, 16'sh8000);
    send_beat(16'sh8000, 16'sh7fff);
    send_beat(16'sh0000, 16'sh0000);
    send_beat(16'shffff, 16'sh0001);
    drain();
    set_regs(int'(MODE_NOTCH), 511, 0, 65535, 65535);
    run_phase(3, 2);
    set_regs(int'(MODE_BYPASS), 5, 200, 0, 0);
    run_phase(3, 0);
    set_regs(int'(MODE_RSVD), 0, 255, 65535, 0);
    run_phase(3, 0);
    set_regs(int'(MODE_NOTCH), 0, 255, 65535, 0);
    run_phase(5, 2);
    set_regs(int'(MODE_NOISE), 0, 1, 65535, 0);
    run_phase(4, 2);

    // random part
    while (items_sent < 1400) begin
      md = $urandom_range(99) < 45 ? int'(MODE_NOISE)
           : ($urandom_range(99) < 85 ? int'(MODE_NOTCH)
           : ($urandom_range(1) ? int'(MODE_BYPASS) : int'(MODE_RSVD)));
      tp = $urandom_range(99) < 85 ? $urandom_range(16, 1)
           : ($urandom_range(1) ? 128 : $urandom_range(255, 17));
      if ($urandom_range(9) == 0) tp = 0;
      set_regs(md, $urandom_range(99) < 70 ? $urandom_range(8) : $urandom_range(511),
               tp, $urandom_range(1) ? $urandom_range(65535) : (1 << $urandom_range(15)),
               $urandom_range(1) ? 0 : $urandom_range(65535));
      no_idle = ($urandom_range(7) == 0);
      if ($urandom_range(9) == 0) hold_req = 1'b1;
      run_phase($urandom_range(120, 40), $urandom_range(99) < 75 ? 1
                : ($urandom_range(9) == 0 ? 2 : 0));
      no_idle = 1'b0;
    end
    hold_req = 1'b1;
    set_regs(int'(MODE_NOTCH), 0, 4, 4096, 16);
    run_phase(10, 1);

    if (fail_count == 0 && backlog == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* leaky_nlms_adaptive_filter.f */
rtl/core/lnaf_pkg.sv
rtl/core/lnaf_in_if.sv
rtl/core/lnaf_out_if.sv
rtl/core/lnaf_div.sv
rtl/core/leaky_nlms_adaptive_filter.sv
tb/sv/lnaf_checker.sv
tb/sv/tb_top.sv
